// File: sv/tcd_pkg.sv
// Shared types and command codes for the trip command deframer.
// Used by tcd_front, tcd_back and trip_command_deframer_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcd_pkg;

	// Command byte codes
	localparam logic [7:0] CMD_TRIP         = 8'h10;
	localparam logic [7:0] CMD_CLEAR_TRIP   = 8'h11;
	localparam logic [7:0] CMD_DISABLE      = 8'h12;
	localparam logic [7:0] CMD_ENABLE       = 8'h13;
	localparam logic [7:0] CMD_Q_TRIP       = 8'h14;
	localparam logic [7:0] CMD_Q_MASK       = 8'h15;
	localparam logic [7:0] CMD_SET_THR      = 8'h16;
	localparam logic [7:0] CMD_SET_REQ      = 8'h17;
	localparam logic [7:0] CMD_Q_THR        = 8'h18;
	localparam logic [7:0] CMD_PEDESTAL_ON  = 8'h20;
	localparam logic [7:0] CMD_PEDESTAL_OFF = 8'h21;
	localparam logic [7:0] CMD_BUF_START    = 8'h32;
	localparam logic [7:0] CMD_BUF_STOP     = 8'h33;
	localparam logic [7:0] CMD_Q_BUF        = 8'h36;

	// Payload bytes kept per frame
	localparam int HEAD_DEPTH = 5;
	// Channel index field width, enough for the largest channel count
	localparam int CH_IDX_W   = 3;

	// Decoded operation, length already checked
	typedef enum logic [3:0] {
		OP_NONE,
		OP_TRIP,
		OP_RESET_TRIP,
		OP_DISABLE,
		OP_ENABLE,
		OP_Q_TRIP,
		OP_Q_MASK,
		OP_SET_THR,
		OP_SET_REQ,
		OP_Q_THR,
		OP_PED_ON,
		OP_PED_OFF,
		OP_BUF_START,
		OP_BUF_STOP,
		OP_Q_BUF
	} op_t;

	// One job per received byte, front to back
	typedef struct packed {
		op_t                 op;
		logic                ch_ok;
		logic [CH_IDX_W-1:0] ch;
		logic [31:0]         data;
	} job_t;

	// One result transaction
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       last;
		logic [5:0] crowbar;
		logic       pedestal;
	} res_t;

endpackage

`default_nettype wire

// File: sv/tcd_fifo.sv
// Small register queue for packed transactions.
// Generic; used for the job queue and the result queue of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module tcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pop) |=> (count_q == $past(count_q)))
		else $error("occupancy moved on simultaneous push and pop");

endmodule

`default_nettype wire

// File: sv/tcd_front.sv
// Frame parser: takes command, length and payload bytes and emits one job per byte.
// Depends on tcd_pkg for the command codes and the job type.
`timescale 1ns / 1ps
`default_nettype none

module tcd_front #(
	parameter int MAX_PAYLOAD = 64,
	parameter int CHANNELS    = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [7:0]  rx_byte,
	output logic             full,
	input  wire logic        job_full,
	output logic             job_push,
	output tcd_pkg::job_t    job
);

	import tcd_pkg::*;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [2:0] {
		PH_CMD = 3'b001,
		PH_LEN = 3'b010,
		PH_PAY = 3'b100
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       cmd_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic [7:0]       head_q [HEAD_DEPTH];

	logic [7:0]       head_m [HEAD_DEPTH];
	logic [LEN_W-1:0] cnt_inc;
	logic             accept;
	logic             run;
	logic [7:0]       run_len;

	function automatic op_t decode(input logic [7:0] cmd, input logic [7:0] len);
		op_t op;
		case (cmd)
			CMD_TRIP:         op = (len == 8'd1) ? OP_TRIP : OP_NONE;
			CMD_CLEAR_TRIP:   op = (len == 8'd1) ? OP_RESET_TRIP : OP_NONE;
			CMD_DISABLE:      op = (len == 8'd1) ? OP_DISABLE : OP_NONE;
			CMD_ENABLE:       op = (len == 8'd1) ? OP_ENABLE : OP_NONE;
			CMD_Q_TRIP:       op = (len == 8'd0) ? OP_Q_TRIP : OP_NONE;
			CMD_Q_MASK:       op = (len == 8'd0) ? OP_Q_MASK : OP_NONE;
			CMD_SET_THR:      op = (len == 8'd5) ? OP_SET_THR : OP_NONE;
			CMD_SET_REQ:      op = (len == 8'd3) ? OP_SET_REQ : OP_NONE;
			CMD_Q_THR:        op = (len == 8'd0) ? OP_Q_THR : OP_NONE;
			CMD_PEDESTAL_ON:  op = (len == 8'd0) ? OP_PED_ON : OP_NONE;
			CMD_PEDESTAL_OFF: op = (len == 8'd0) ? OP_PED_OFF : OP_NONE;
			CMD_BUF_START:    op = (len == 8'd0) ? OP_BUF_START : OP_NONE;
			CMD_BUF_STOP:     op = (len == 8'd0) ? OP_BUF_STOP : OP_NONE;
			CMD_Q_BUF:        op = (len == 8'd0) ? OP_Q_BUF : OP_NONE;
			default:          op = OP_NONE;
		endcase
		return op;
	endfunction

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign job_push = accept;
	assign cnt_inc  = cnt_q + 1'b1;

	// Merge the current payload byte into the kept head
	always_comb begin
		for (int i = 0; i < HEAD_DEPTH; i++) begin
			head_m[i] = ((phase_q == PH_PAY) && (cnt_q == LEN_W'(i))) ? rx_byte : head_q[i];
		end
	end

	// Classify the byte: frame end runs the command
	always_comb begin
		run     = 1'b0;
		run_len = 8'd0;
		case (phase_q)
			PH_LEN: begin
				run     = (rx_byte == 8'd0);
				run_len = 8'd0;
			end
			PH_PAY: begin
				run     = (cnt_inc == len_q);
				run_len = 8'(len_q);
			end
			default: begin
				run     = 1'b0;
				run_len = 8'd0;
			end
		endcase
		job.op    = run ? decode(cmd_q, run_len) : OP_NONE;
		job.ch_ok = (head_m[0] < 8'(CHANNELS));
		job.ch    = head_m[0][CH_IDX_W-1:0];
		job.data  = {head_m[4], head_m[3], head_m[2], head_m[1]};
	end

	// Keep payload head bytes
	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_PAY) && (cnt_q < LEN_W'(HEAD_DEPTH))) begin
			head_q[cnt_q[2:0]] <= rx_byte;
		end
	end

	// Advance the parse phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			cmd_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_CMD: begin
					cmd_q   <= rx_byte;
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					cnt_q <= '0;
					len_q <= LEN_W'(rx_byte);
					if ((rx_byte > 8'(MAX_PAYLOAD)) || (rx_byte == 8'd0)) begin
						phase_q <= PH_CMD;
					end else begin
						phase_q <= PH_PAY;
					end
				end
				PH_PAY: begin
					cnt_q <= cnt_inc;
					if (cnt_inc == len_q) begin
						phase_q <= PH_CMD;
					end
				end
				default: begin
					phase_q <= PH_CMD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/tcd_back.sv
// Command executor: applies jobs to the channel state and emits result transactions.
// Depends on tcd_pkg for the job and result types.
`timescale 1ns / 1ps
`default_nettype none

module tcd_back #(
	parameter int CHANNELS = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tcd_pkg::job_t job,
	input  wire logic          job_empty,
	output logic               job_pop,
	input  wire logic          res_full,
	output logic               res_push,
	output tcd_pkg::res_t      res
);

	import tcd_pkg::*;

	localparam int CHI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t              state_q;
	logic [CHI_W-1:0]    wi_q;
	logic [1:0]          bi_q;
	logic [CHANNELS-1:0] enable_q;
	logic [CHANNELS-1:0] tripped_q;
	logic [31:0]         thr_q [CHANNELS];
	logic [15:0]         req_q [CHANNELS];
	logic                ped_q;
	logic                buf_q;

	logic [CHANNELS-1:0] chan_bit;
	logic [CHI_W-1:0]    ch_idx;
	logic [CHANNELS-1:0] enable_d;
	logic [CHANNELS-1:0] tripped_d;
	logic                ped_d;
	logic                buf_d;
	logic                emit;
	logic                dumping;
	logic                dump_last;
	logic [7:0]          dump_byte;
	logic [7:0]          trip_ext;

	assign emit      = !res_full && ((state_q == ST_DUMP) || !job_empty);
	assign job_pop   = emit && (state_q == ST_RUN);
	assign dumping   = emit && ((state_q == ST_DUMP) || (job.op == OP_Q_THR));
	assign dump_last = (wi_q == CHI_W'(CHANNELS - 1)) && (bi_q == 2'd3);
	assign dump_byte = 8'(thr_q[wi_q] >> {bi_q, 3'b000});
	assign ch_idx    = job.ch[CHI_W-1:0];
	assign chan_bit  = job.ch_ok ? (CHANNELS'(1) << job.ch) : '0;

	// Compute the channel state after this job
	always_comb begin
		enable_d  = enable_q;
		tripped_d = tripped_q;
		ped_d     = ped_q;
		buf_d     = buf_q;
		if (job_pop) begin
			case (job.op)
				OP_TRIP: begin
					if ((enable_q & chan_bit) != '0) begin
						buf_d     = 1'b0;
						tripped_d = tripped_q | chan_bit;
					end
				end
				OP_RESET_TRIP: begin
					if (job.ch_ok) begin
						buf_d     = 1'b1;
						tripped_d = tripped_q & ~chan_bit;
						enable_d  = enable_q | chan_bit;
					end
				end
				OP_DISABLE:   enable_d = enable_q & ~chan_bit;
				OP_ENABLE:    enable_d = enable_q | chan_bit;
				OP_PED_ON:    ped_d = 1'b1;
				OP_PED_OFF:   ped_d = 1'b0;
				OP_BUF_START: buf_d = 1'b1;
				OP_BUF_STOP:  buf_d = 1'b0;
				default: begin
					enable_d = enable_q;
				end
			endcase
		end
	end

	// Build the result transaction
	always_comb begin
		trip_ext     = 8'(tripped_d);
		res.crowbar  = trip_ext[5:0];
		res.pedestal = ped_d;
		res.tx_byte  = 8'd0;
		res.tx_valid = 1'b0;
		res.last     = 1'b1;
		if ((state_q == ST_DUMP) || (job.op == OP_Q_THR)) begin
			res.tx_byte  = dump_byte;
			res.tx_valid = 1'b1;
			res.last     = dump_last;
		end else begin
			case (job.op)
				OP_Q_TRIP: begin
					res.tx_byte  = 8'(tripped_q);
					res.tx_valid = 1'b1;
				end
				OP_Q_MASK: begin
					res.tx_byte  = 8'(enable_q);
					res.tx_valid = 1'b1;
				end
				OP_Q_BUF: begin
					res.tx_byte  = 8'(buf_q);
					res.tx_valid = 1'b1;
				end
				default: begin
					res.tx_byte  = 8'd0;
					res.tx_valid = 1'b0;
				end
			endcase
		end
	end

	assign res_push = emit;

	// Hold channel state, store set commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= '0;
			tripped_q <= '0;
			ped_q     <= 1'b0;
			buf_q     <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				thr_q[i] <= '0;
				req_q[i] <= '0;
			end
		end else begin
			enable_q  <= enable_d;
			tripped_q <= tripped_d;
			ped_q     <= ped_d;
			buf_q     <= buf_d;
			if (job_pop && job.ch_ok && (job.op == OP_SET_THR)) begin
				thr_q[ch_idx] <= job.data;
			end
			if (job_pop && job.ch_ok && (job.op == OP_SET_REQ)) begin
				req_q[ch_idx] <= job.data[15:0];
			end
		end
	end

	// Step through the threshold dump, one byte per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			wi_q    <= '0;
			bi_q    <= '0;
		end else if (dumping) begin
			if (dump_last) begin
				wi_q    <= '0;
				bi_q    <= '0;
				state_q <= ST_RUN;
			end else begin
				bi_q    <= bi_q + 1'b1;
				wi_q    <= (bi_q == 2'd3) ? wi_q + 1'b1 : wi_q;
				state_q <= ST_DUMP;
			end
		end
	end

	a_run_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((wi_q == '0) && (bi_q == '0)))
		else $error("dump counters not cleared outside a dump");

	a_no_pop_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> !job_pop)
		else $error("job taken during a threshold dump");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res.tx_valid) |-> res.last)
		else $error("status-only result not marked last");

endmodule

`default_nettype wire

// File: sv/trip_command_deframer_top.sv
// Trip command deframer: received command frames in, response transactions out.
// Instantiates tcd_front, tcd_fifo (job and result queues) and tcd_back; uses tcd_pkg.
//
// Input channel: rx_byte is taken at a clock edge with push high and full low.
// Frames are command byte, length byte, then length payload bytes.
// Result channel: while empty is low the oldest result sits on tx_byte, tx_valid,
// last, crowbar_drive and pedestal_drive; pop high takes it at the clock edge.
// Every byte yields one result, or one per response byte with last on the final one.
// Path: a byte's job is registered in the job queue, its result in the result queue.
// Throughput: one byte per cycle while full is low; a threshold query holds the
// executor while it sends its 4*CHANNELS response bytes, and the 4-entry job
// queue lets the parser keep taking bytes meanwhile until it fills.
// Reset: parser waits for a command byte, channel state and thresholds are
// cleared, both queues are empty.
// Receiver stall: the result queue fills, the executor holds, the job queue
// fills and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module trip_command_deframer_top #(
	parameter int MAX_PAYLOAD = 64,
	parameter int CHANNELS    = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] rx_byte,
	output logic            full,
	input  wire logic       pop,
	output logic            empty,
	output logic [7:0]      tx_byte,
	output logic            tx_valid,
	output logic            last,
	output logic [5:0]      crowbar_drive,
	output logic            pedestal_drive
);

	import tcd_pkg::*;

	localparam int JOB_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	job_t job_in;
	job_t job_out;
	logic job_push;
	logic job_pop;
	logic job_full;
	logic job_empty;
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;

	// Parse and classify incoming bytes
	tcd_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.CHANNELS   (CHANNELS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.full    (full),
		.job_full(job_full),
		.job_push(job_push),
		.job     (job_in)
	);

	// Decouple parser from executor
	tcd_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.rdata (job_out),
		.empty (job_empty)
	);

	// Execute commands and serialize responses
	tcd_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job_out),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// Hold results for the receiver
	tcd_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop && !empty),
		.rdata (res_out),
		.empty (empty)
	);

	assign tx_byte        = res_out.tx_byte;
	assign tx_valid       = res_out.tx_valid;
	assign last           = res_out.last;
	assign crowbar_drive  = res_out.crowbar;
	assign pedestal_drive = res_out.pedestal;

endmodule

`default_nettype wire

// File: verif/trip_command_deframer_top_test.sv
// Self-checking testbench for trip_command_deframer_top: directed frames, then random frames.
// Depends on tcd_pkg for the command codes and the result layout; carries its own predictor.
`timescale 1ns / 1ps

module trip_command_deframer_top_test;
	import tcd_pkg::*;

	localparam int MAX_PAYLOAD  = 64;
	localparam int CHANNELS     = 6;
	localparam int RANDOM_BYTES = 250;
	localparam int MAX_REPORTS  = 10;
	localparam int SETTLE       = 32;

	// Payload lengths that the commands take
	localparam int LEN_CHAN = 1;
	localparam int LEN_REQ  = 3;
	localparam int LEN_THR  = 5;

	localparam logic [7:0] CMD_UNKNOWN = 8'hFF;

	localparam logic [7:0] KNOWN_COMMANDS [14] = '{
		CMD_TRIP, CMD_CLEAR_TRIP, CMD_DISABLE, CMD_ENABLE, CMD_Q_TRIP, CMD_Q_MASK,
		CMD_SET_THR, CMD_SET_REQ, CMD_Q_THR, CMD_PEDESTAL_ON, CMD_PEDESTAL_OFF,
		CMD_BUF_START, CMD_BUF_STOP, CMD_Q_BUF
	};

	typedef enum logic [1:0] {
		WAIT_CMD,
		WAIT_LEN,
		IN_PAYLOAD
	} frame_phase_t;

	typedef enum logic [1:0] {
		POP_ALWAYS,
		POP_HALF,
		POP_SPARSE,
		POP_HOLD
	} drain_style_t;

	// One line of the directed script; fixed rows carry a hand-typed result
	typedef struct packed {
		logic [7:0] rx;
		logic       fixed;
		res_t       want;
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] tx_byte;
	logic       tx_valid;
	logic       last;
	logic [5:0] crowbar_drive;
	logic       pedestal_drive;

	// Predicted channel and parser state
	frame_phase_t frame_phase = WAIT_CMD;
	logic [7:0]   cmd_code = 8'h00;
	logic [7:0]   frame_len = 8'h00;
	int           frame_cnt = 0;
	logic [7:0]   head [HEAD_DEPTH];
	logic [5:0]   en_mask = 6'h00;
	logic [5:0]   trip_bits = 6'h00;
	logic [31:0]  thr_word [CHANNELS];
	logic [15:0]  req_cnt [CHANNELS];
	logic         ped_on = 1'b0;
	logic         buf_run = 1'b0;
	logic [7:0]   reply [$];

	res_t         pending_results [$];
	script_row_t  script [$];

	int           burst_left = 0;
	int           bytes_sent = 0;
	int           frames_sent = 0;
	int           results_checked = 0;
	int           mismatches = 0;
	drain_style_t drain_style = POP_ALWAYS;
	int           drain_left = 0;

	trip_command_deframer_top #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.CHANNELS   (CHANNELS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.rx_byte       (rx_byte),
		.full          (full),
		.pop           (pop),
		.empty         (empty),
		.tx_byte       (tx_byte),
		.tx_valid      (tx_valid),
		.last          (last),
		.crowbar_drive (crowbar_drive),
		.pedestal_drive(pedestal_drive)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Carry out a complete frame; responses go to reply
	function automatic void apply_command();
		logic [7:0] ch;
		logic       ch_ok;
		logic [5:0] sel;
		ch    = head[0];
		ch_ok = ch < CHANNELS;
		sel   = ch_ok ? (6'd1 << ch[2:0]) : 6'd0;
		case (cmd_code)
			CMD_TRIP: begin
				if (frame_len == LEN_CHAN && ch_ok && (en_mask & sel) != 6'd0) begin
					buf_run   = 1'b0;
					trip_bits = trip_bits | sel;
				end
			end
			CMD_CLEAR_TRIP: begin
				if (frame_len == LEN_CHAN && ch_ok) begin
					buf_run   = 1'b1;
					trip_bits = trip_bits & ~sel;
					en_mask   = en_mask | sel;
				end
			end
			CMD_DISABLE: begin
				if (frame_len == LEN_CHAN && ch_ok) en_mask = en_mask & ~sel;
			end
			CMD_ENABLE: begin
				if (frame_len == LEN_CHAN && ch_ok) en_mask = en_mask | sel;
			end
			CMD_Q_TRIP: begin
				if (frame_len == 0) reply.push_back({2'b00, trip_bits});
			end
			CMD_Q_MASK: begin
				if (frame_len == 0) reply.push_back({2'b00, en_mask});
			end
			CMD_SET_THR: begin
				if (frame_len == LEN_THR && ch_ok)
					thr_word[ch] = {head[4], head[3], head[2], head[1]};
			end
			CMD_SET_REQ: begin
				if (frame_len == LEN_REQ && ch_ok) req_cnt[ch] = {head[2], head[1]};
			end
			CMD_Q_THR: begin
				if (frame_len == 0)
					for (int i = 0; i < CHANNELS; i++)
						for (int k = 0; k < 4; k++)
							reply.push_back(thr_word[i][8*k +: 8]);
			end
			CMD_PEDESTAL_ON: begin
				if (frame_len == 0) ped_on = 1'b1;
			end
			CMD_PEDESTAL_OFF: begin
				if (frame_len == 0) ped_on = 1'b0;
			end
			CMD_BUF_START: begin
				if (frame_len == 0) buf_run = 1'b1;
			end
			CMD_BUF_STOP: begin
				if (frame_len == 0) buf_run = 1'b0;
			end
			CMD_Q_BUF: begin
				if (frame_len == 0) reply.push_back({7'd0, buf_run});
			end
			default: begin
			end
		endcase
	endfunction

	// Advance the frame parser by one received byte
	function automatic void deframe_byte(input logic [7:0] b);
		reply.delete();
		case (frame_phase)
			WAIT_CMD: begin
				cmd_code    = b;
				frame_phase = WAIT_LEN;
			end
			WAIT_LEN: begin
				frame_len = b;
				frame_cnt = 0;
				if (b > MAX_PAYLOAD) begin
					frame_phase = WAIT_CMD;
				end else if (b == 8'd0) begin
					apply_command();
					frame_phase = WAIT_CMD;
				end else begin
					frame_phase = IN_PAYLOAD;
				end
			end
			default: begin
				if (frame_cnt < HEAD_DEPTH) head[frame_cnt] = b;
				frame_cnt++;
				if (frame_cnt >= frame_len) begin
					apply_command();
					frame_phase = WAIT_CMD;
				end
			end
		endcase
	endfunction

	function automatic int needed_length(input logic [7:0] cmd);
		case (cmd)
			CMD_TRIP, CMD_CLEAR_TRIP, CMD_DISABLE, CMD_ENABLE: return LEN_CHAN;
			CMD_SET_REQ: return LEN_REQ;
			CMD_SET_THR: return LEN_THR;
			default:     return 0;
		endcase
	endfunction

	function automatic void add_row(input logic [7:0] rx, input logic fixed = 1'b0,
			input res_t want = '0);
		script.push_back({rx, fixed, want});
	endfunction

	// Send one byte in bursts, then queue what it should produce
	task automatic send_byte(input logic [7:0] b, input logic fixed = 1'b0,
			input res_t want = '0);
		int   gap;
		res_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
		deframe_byte(b);
		if (fixed) begin
			pending_results.push_back(want);
		end else if (reply.size() == 0) begin
			r = {8'h00, 1'b0, 1'b1, trip_bits, ped_on};
			pending_results.push_back(r);
		end else begin
			foreach (reply[k]) begin
				r = {reply[k], 1'b1, k == reply.size() - 1, trip_bits, ped_on};
				pending_results.push_back(r);
			end
		end
	endtask

	// Hold the sender until every queued result has come out
	task automatic drain_pause();
		push <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
	endtask

	// Mostly well-formed frames, with bad lengths, bad channels and stray bytes mixed in
	task automatic random_frame();
		int         pick;
		int         len;
		logic [7:0] cmd;
		frames_sent++;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			send_byte(8'($urandom_range(0, 255)));
			return;
		end
		cmd  = (pick < 10) ? 8'($urandom_range(0, 255)) : KNOWN_COMMANDS[$urandom_range(0, 13)];
		pick = $urandom_range(0, 99);
		if (pick < 80)
			len = needed_length(cmd);
		else if (pick < 88)
			len = $urandom_range(0, 6);
		else if (pick < 94)
			len = ($urandom_range(0, 1) == 0) ? MAX_PAYLOAD + 1
				: $urandom_range(MAX_PAYLOAD + 1, 255);
		else
			len = ($urandom_range(0, 2) == 0) ? MAX_PAYLOAD : $urandom_range(6, MAX_PAYLOAD);
		send_byte(cmd);
		send_byte(8'(len));
		if (len <= MAX_PAYLOAD) begin
			for (int k = 0; k < len; k++) begin
				if (k == 0)
					send_byte(($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, CHANNELS - 1))
						: 8'($urandom_range(CHANNELS, 255)));
				else
					send_byte(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 19) == 0) drain_pause();
	endtask

	// Stall the result side in stretches of differing pressure
	always @(posedge clk) begin
		if (drain_left == 0) begin
			drain_style = drain_style_t'($urandom_range(0, 3));
			drain_left  = $urandom_range(16, 96);
		end
		drain_left--;
		case (drain_style)
			POP_ALWAYS: pop <= 1'b1;
			POP_HALF:   pop <= ($urandom_range(0, 1) == 0);
			POP_SPARSE: pop <= ($urandom_range(0, 7) == 0);
			default:    pop <= 1'b0;
		endcase
	end

	// Compare each popped transaction with the oldest expectation
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			got = {tx_byte, tx_valid, last, crowbar_drive, pedestal_drive};
			results_checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with nothing expected: tx_byte %02h tx_valid %0b",
						$realtime, got.tx_byte, got.tx_valid);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: mismatch (expected/actual) tx_byte %02h/%02h",
							$realtime, want.tx_byte, got.tx_byte,
							" tx_valid %0b/%0b last %0b/%0b",
							want.tx_valid, got.tx_valid, want.last, got.last,
							" crowbar %02h/%02h pedestal %0b/%0b",
							want.crowbar, got.crowbar, want.pedestal, got.pedestal);
				end
			end
		end
	end

	initial begin
		res_t quiet;
		res_t zero_reply;
		foreach (head[i]) head[i] = 8'h00;
		foreach (thr_word[i]) begin
			thr_word[i] = 32'd0;
			req_cnt[i]  = 16'd0;
		end
		quiet      = {8'h00, 1'b0, 1'b1, 6'h00, 1'b0};
		zero_reply = {8'h00, 1'b1, 1'b1, 6'h00, 1'b0};

		// Query trips after reset, then an unknown command with an oversized length
		add_row(CMD_Q_TRIP, 1'b1, quiet);
		add_row(8'h00, 1'b1, zero_reply);
		add_row(CMD_UNKNOWN, 1'b1, quiet);
		add_row(8'hFF, 1'b1, quiet);
		// Arm the top channel, trip it, read back mask and buffer state
		add_row(CMD_CLEAR_TRIP); add_row(8'h01); add_row(8'h05);
		add_row(CMD_TRIP);       add_row(8'h01); add_row(8'h05);
		add_row(CMD_Q_MASK);     add_row(8'h00);
		add_row(CMD_Q_BUF);      add_row(8'h00);
		// Store a threshold on channel 0 and read every threshold back
		add_row(CMD_SET_THR); add_row(8'h05); add_row(8'h00);
		add_row(8'hFF); add_row(8'h00); add_row(8'hA5); add_row(8'h5A);
		add_row(CMD_Q_THR); add_row(8'h00);
		// Requirement on a channel out of range is dropped
		add_row(CMD_SET_REQ); add_row(8'h03); add_row(8'h06); add_row(8'h34); add_row(8'h12);
		add_row(CMD_DISABLE);      add_row(8'h01); add_row(8'h05);
		add_row(CMD_ENABLE);       add_row(8'h01); add_row(8'h00);
		add_row(CMD_PEDESTAL_ON);  add_row(8'h00);
		add_row(CMD_BUF_START);    add_row(8'h00);
		add_row(CMD_BUF_STOP);     add_row(8'h00);
		add_row(CMD_PEDESTAL_OFF); add_row(8'h00);
		// Query with a payload it does not take
		add_row(CMD_Q_TRIP); add_row(8'h01); add_row(8'h00);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) send_byte(script[i].rx, script[i].fixed, script[i].want);
		drain_pause();

		while (bytes_sent < script.size() + RANDOM_BYTES) random_frame();
		push <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);

		$display("Summary: %0d directed bytes and %0d random frames, %0d bytes in all;",
			script.size(), frames_sent, bytes_sent);
		$display("Summary: %0d result transactions checked, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
